FILE: rtl/tpahc_pkg.sv
// Shared widths, reset values, register indexes and types for the triac heater control.
package tpahc_pkg;

   localparam int SAMPLE_BITS  = 10;
   localparam int COUNT_BITS   = 16;
   localparam int GAIN_BITS    = 8;
   localparam int PRODUCT_BITS = GAIN_BITS + SAMPLE_BITS;
   localparam int WIDE_BITS    = PRODUCT_BITS + COUNT_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;

   localparam int REQ_FIELD_BITS = 2 * SAMPLE_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = COUNT_BITS + 3;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [SAMPLE_BITS-1:0] TARGET_LOW_PIN_RESET  = SAMPLE_BITS'(900);
   localparam logic [SAMPLE_BITS-1:0] TARGET_HIGH_PIN_RESET = SAMPLE_BITS'(800);
   localparam logic [SAMPLE_BITS-1:0] WINDOW_LOW_RESET      = SAMPLE_BITS'(100);
   localparam logic [SAMPLE_BITS-1:0] WINDOW_HIGH_RESET     = SAMPLE_BITS'(300);
   localparam logic [COUNT_BITS-1:0]  BASE_DELAY_RESET      = COUNT_BITS'(7200);
   localparam logic [GAIN_BITS-1:0]   SHORTFALL_GAIN_RESET  = GAIN_BITS'(26);
   localparam logic [COUNT_BITS-1:0]  IDLE_DELAY_RESET      = COUNT_BITS'(7500);
   localparam logic [COUNT_BITS-1:0]  DELAY_STORE_RESET     = COUNT_BITS'(50 - 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_LOW_PIN  = 3'd0,
      CSR_TARGET_HIGH_PIN = 3'd1,
      CSR_WINDOW_LOW      = 3'd2,
      CSR_WINDOW_HIGH     = 3'd3,
      CSR_BASE_DELAY      = 3'd4,
      CSR_SHORTFALL_GAIN  = 3'd5,
      CSR_IDLE_DELAY      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] target_low_pin;
      logic [SAMPLE_BITS-1:0] target_high_pin;
      logic [SAMPLE_BITS-1:0] window_low;
      logic [SAMPLE_BITS-1:0] window_high;
      logic [COUNT_BITS-1:0]  base_delay;
      logic [GAIN_BITS-1:0]   shortfall_gain;
      logic [COUNT_BITS-1:0]  idle_delay;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] temp_sample;
      logic [SAMPLE_BITS-1:0] mains_sample;
      logic                   standby_high;
   } tick_type;

   typedef struct packed {
      logic                  fire;
      logic                  waiting;
      logic [COUNT_BITS-1:0] delay_value;
      logic                  delay_clamped;
   } result_type;

endpackage

FILE: rtl/tpahc_csr.sv
// Configuration register file for the triac heater control.
module tpahc_csr import tpahc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_LOW_PIN:  cfg_in.target_low_pin  = csr_data[SAMPLE_BITS-1:0];
            CSR_TARGET_HIGH_PIN: cfg_in.target_high_pin = csr_data[SAMPLE_BITS-1:0];
            CSR_WINDOW_LOW:      cfg_in.window_low      = csr_data[SAMPLE_BITS-1:0];
            CSR_WINDOW_HIGH:     cfg_in.window_high     = csr_data[SAMPLE_BITS-1:0];
            CSR_BASE_DELAY:      cfg_in.base_delay      = csr_data[COUNT_BITS-1:0];
            CSR_SHORTFALL_GAIN:  cfg_in.shortfall_gain  = csr_data[GAIN_BITS-1:0];
            CSR_IDLE_DELAY:      cfg_in.idle_delay      = csr_data[COUNT_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_low_pin  <= TARGET_LOW_PIN_RESET;
         cfg_ff.target_high_pin <= TARGET_HIGH_PIN_RESET;
         cfg_ff.window_low      <= WINDOW_LOW_RESET;
         cfg_ff.window_high     <= WINDOW_HIGH_RESET;
         cfg_ff.base_delay      <= BASE_DELAY_RESET;
         cfg_ff.shortfall_gain  <= SHORTFALL_GAIN_RESET;
         cfg_ff.idle_delay      <= IDLE_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/tpahc_core.sv
// Input register, control state and the per-tick update of the triac heater control.
module tpahc_core import tpahc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  tick_type   in_tick,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic                   tick_valid_ff;
   logic                   tick_valid_in;
   tick_type               tick_ff;
   logic                   wait_active_ff;
   logic                   wait_active_in;
   logic [COUNT_BITS-1:0]  countdown_ff;
   logic [COUNT_BITS-1:0]  countdown_in;
   logic [COUNT_BITS-1:0]  delay_store_ff;
   logic [COUNT_BITS-1:0]  delay_store_in;
   logic                   fire_level_ff;
   logic                   fire_level_in;
   logic                   clamp_flag_ff;
   logic                   clamp_flag_in;

   logic                   advance;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] target;
   logic                   in_window;
   logic [SAMPLE_BITS-1:0] shortfall;
   logic [PRODUCT_BITS-1:0] product;
   logic                   over_base;

   assign advance  = tick_valid_ff && out_ready;
   assign in_ready = !tick_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   assign target    = tick_ff.standby_high ? cfg.target_high_pin : cfg.target_low_pin;
   assign in_window = (tick_ff.mains_sample > cfg.window_low) &&
                      (tick_ff.mains_sample < cfg.window_high);
   assign shortfall = target - tick_ff.temp_sample;
   assign product   = PRODUCT_BITS'(cfg.shortfall_gain) * PRODUCT_BITS'(shortfall);
   assign over_base = WIDE_BITS'(product) > WIDE_BITS'(cfg.base_delay);

   always_comb begin
      wait_active_in = wait_active_ff;
      countdown_in   = countdown_ff;
      delay_store_in = delay_store_ff;
      fire_level_in  = fire_level_ff;
      clamp_flag_in  = clamp_flag_ff;
      if (wait_active_ff) begin
         if (countdown_ff == '0) begin
            fire_level_in  = 1'b1;
            wait_active_in = 1'b0;
         end else begin
            countdown_in = countdown_ff - 1'b1;
         end
      end else begin
         if (in_window) begin
            countdown_in   = delay_store_ff;
            wait_active_in = 1'b1;
         end else begin
            fire_level_in = 1'b0;
         end
         // The new delay only applies to the next window entry.
         if (tick_ff.temp_sample < target) begin
            if (over_base) begin
               delay_store_in = '0;
               clamp_flag_in  = 1'b1;
            end else begin
               delay_store_in = cfg.base_delay - COUNT_BITS'(WIDE_BITS'(product));
               clamp_flag_in  = 1'b0;
            end
         end else begin
            delay_store_in = cfg.idle_delay;
            clamp_flag_in  = 1'b0;
         end
      end
   end

   always_comb begin
      if (accept) begin
         tick_valid_in = 1'b1;
      end else if (advance) begin
         tick_valid_in = 1'b0;
      end else begin
         tick_valid_in = tick_valid_ff;
      end
   end

   assign out_valid                = tick_valid_ff;
   assign out_result.fire          = fire_level_in;
   assign out_result.waiting       = wait_active_in;
   assign out_result.delay_value   = delay_store_in;
   assign out_result.delay_clamped = clamp_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff  <= 1'b0;
         wait_active_ff <= 1'b0;
         countdown_ff   <= '0;
         delay_store_ff <= DELAY_STORE_RESET;
         fire_level_ff  <= 1'b0;
         clamp_flag_ff  <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         if (advance) begin
            wait_active_ff <= wait_active_in;
            countdown_ff   <= countdown_in;
            delay_store_ff <= delay_store_in;
            fire_level_ff  <= fire_level_in;
            clamp_flag_ff  <= clamp_flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tick_ff <= in_tick;
      end
   end

endmodule

FILE: rtl/tpahc_skid.sv
// Two-entry result buffer that absorbs stalls on the result side until both entries are held.
module tpahc_skid import tpahc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  result_type push_result,
   output logic       pop_valid,
   input  logic       pop_ready,
   output result_type pop_result
);

   logic       main_valid_ff;
   logic       main_valid_in;
   logic       spare_valid_ff;
   logic       spare_valid_in;
   result_type main_ff;
   result_type main_in;
   result_type spare_ff;
   result_type spare_in;
   logic       push;
   logic       pop;

   assign push_ready = !spare_valid_ff;
   assign push       = push_valid && !spare_valid_ff;
   assign pop        = main_valid_ff && pop_ready;
   assign pop_valid  = main_valid_ff;
   assign pop_result = main_ff;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_in        = main_ff;
      spare_in       = spare_ff;
      if (spare_valid_ff) begin
         if (pop) begin
            main_in        = spare_ff;
            spare_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_result;
            main_valid_in = 1'b1;
         end else begin
            spare_in       = push_result;
            spare_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

endmodule

FILE: rtl/triac_phase_angle_heater_control.sv
// Top level of the triac phase-angle heater control.
//
//   Channel | Direction | Handshake               | Payload
//   req     | in        | req_tvalid / req_tready | req_tdata: temp_sample, mains_sample,
//           |           |                         |            standby_high
//   rsp     | out       | rsp_tvalid / rsp_tready | rsp_tdata: fire, waiting, delay_value,
//           |           |                         |            delay_clamped
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One tick is taken every cycle while the result buffer has room. A tick is held in the
// input register, where the control state is updated, and its result is registered in
// the result buffer before it appears on rsp.
// Reset is synchronous and active high; it restores the register reset values and
// clears the countdown, the gate level and all valid flags.
// A stall on rsp is absorbed by a two-entry result buffer, so req_tready only
// drops once both entries are held and the input register is full as well.
module triac_phase_angle_heater_control import tpahc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0: temp_sample, mains_sample, standby_high, zero fill.
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0: fire, waiting, delay_value, delay_clamped, zero fill.
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type    cfg;
   tick_type   req_tick;
   logic       core_valid;
   logic       core_ready;
   result_type core_result;
   result_type rsp_result;

   // Unpack the incoming transfer; the zero fill above the fields is ignored.
   assign req_tick.temp_sample  = req_tdata[SAMPLE_BITS-1:0];
   assign req_tick.mains_sample = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign req_tick.standby_high = req_tdata[2*SAMPLE_BITS];

   tpahc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tpahc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_tick    (req_tick),
      .out_valid  (core_valid),
      .out_ready  (core_ready),
      .out_result (core_result)
   );

   tpahc_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (core_valid),
      .push_ready  (core_ready),
      .push_result (core_result),
      .pop_valid   (rsp_tvalid),
      .pop_ready   (rsp_tready),
      .pop_result  (rsp_result)
   );

   // Pack the outgoing transfer with the first field in the lowest bits.
   assign rsp_tdata = RSP_DATA_BITS'({rsp_result.delay_clamped, rsp_result.delay_value,
                                      rsp_result.waiting, rsp_result.fire});

endmodule

FILE: rtl/tpahc_checker.sv
// Port-level checker for the triac heater control, bound to the top level.
module tpahc_checker import tpahc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // A transfer waiting on rsp is not withdrawn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before the transfer");

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // A saturated delay computation always reports a delay of zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[COUNT_BITS+2] |-> rsp_tdata[COUNT_BITS+1:2] == '0)
      else $error("delay_clamped set with a non-zero delay_value");

   // Reset empties the result path.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind triac_phase_angle_heater_control tpahc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
